[design/cht_pkg.sv]
// ----------------------------------------------------------------------------
// cht_pkg
// Shared types and constants of the coalesced hash table: result codes,
// controller states and the command and status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cht_pkg;

    localparam int KEY_W      = 31;
    localparam int STATUS_W   = 3;
    localparam int SLOT_OUT_W = 4;

    // result codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_INSERTED  = 3'd0,
        STAT_DUPLICATE = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_FOUND     = 3'd3,
        STAT_NOT_FOUND = 3'd4
    } t_status;

    // controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_WALK_RD,
        S_WALK_EV,
        S_PROBE_RD,
        S_PROBE_EV,
        S_LINK
    } t_state;

    // slot store write selection
    typedef enum logic [2:0] {
        WR_NONE,
        WR_CLEAR,
        WR_POS_KEY,
        WR_CAND_KEY,
        WR_END_LINK
    } t_wr_sel;

    // slot store read address selection
    typedef enum logic {
        RD_POS,
        RD_CAND
    } t_rd_sel;

    // result slot selection
    typedef enum logic [1:0] {
        SLOT_ZERO,
        SLOT_POS,
        SLOT_CAND
    } t_slot_sel;

    typedef struct packed {
        logic      clr_step;
        logic      load;
        logic      mod_step;
        logic      follow;
        logic      probe_init;
        logic      probe_next;
        t_rd_sel   rd_sel;
        t_wr_sel   wr_sel;
        logic      res_valid;
        t_status   res_status;
        t_slot_sel slot_sel;
    } t_cmd;

    typedef struct packed {
        logic kind;
        logic clr_last;
        logic mod_done;
        logic used;
        logic link_valid;
        logic key_match;
        logic steps_lt_n;
        logic steps_last;
        logic probe_last;
    } t_stat;

endpackage

`default_nettype wire

[design/cht_ctrl.sv]
// ----------------------------------------------------------------------------
// cht_ctrl
// Controller of the hash table: clearing pass, home slot remainder, chain
// walk, linear probe and link write, one slot visit at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module cht_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire cht_pkg::t_stat i_stat,
    output cht_pkg::t_cmd      o_cmd,
    output logic               o_busy
);
    import cht_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '{clr_step: 1'b0, load: 1'b0, mod_step: 1'b0, follow: 1'b0,
                    probe_init: 1'b0, probe_next: 1'b0, rd_sel: RD_POS,
                    wr_sel: WR_NONE, res_valid: 1'b0, res_status: STAT_INSERTED,
                    slot_sel: SLOT_ZERO};
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                o_cmd.wr_sel   = WR_CLEAR;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_stat.mod_done) begin
                    n_state = S_WALK_RD;
                end
            end
            S_WALK_RD: begin
                o_cmd.rd_sel = RD_POS;
                n_state      = S_WALK_EV;
            end
            S_WALK_EV: begin
                if (!i_stat.kind) begin
                    // insert: empty slot can only be the home slot
                    priority if (!i_stat.used) begin
                        o_cmd.wr_sel     = WR_POS_KEY;
                        o_cmd.res_valid  = 1'b1;
                        o_cmd.res_status = STAT_INSERTED;
                        o_cmd.slot_sel   = SLOT_POS;
                        n_state          = S_IDLE;
                    end else if (i_stat.key_match) begin
                        o_cmd.res_valid  = 1'b1;
                        o_cmd.res_status = STAT_DUPLICATE;
                        n_state          = S_IDLE;
                    end else if (i_stat.link_valid && i_stat.steps_lt_n) begin
                        o_cmd.follow = 1'b1;
                        n_state      = S_WALK_RD;
                    end else begin
                        o_cmd.probe_init = 1'b1;
                        n_state          = S_PROBE_RD;
                    end
                end else begin
                    // find
                    priority if (i_stat.used && i_stat.key_match) begin
                        o_cmd.res_valid  = 1'b1;
                        o_cmd.res_status = STAT_FOUND;
                        o_cmd.slot_sel   = SLOT_POS;
                        n_state          = S_IDLE;
                    end else if (!i_stat.link_valid || i_stat.steps_last) begin
                        o_cmd.res_valid  = 1'b1;
                        o_cmd.res_status = STAT_NOT_FOUND;
                        n_state          = S_IDLE;
                    end else begin
                        o_cmd.follow = 1'b1;
                        n_state      = S_WALK_RD;
                    end
                end
            end
            S_PROBE_RD: begin
                o_cmd.rd_sel = RD_CAND;
                n_state      = S_PROBE_EV;
            end
            S_PROBE_EV: begin
                priority if (!i_stat.used) begin
                    o_cmd.wr_sel = WR_CAND_KEY;
                    n_state      = S_LINK;
                end else if (i_stat.probe_last) begin
                    o_cmd.res_valid  = 1'b1;
                    o_cmd.res_status = STAT_FULL;
                    n_state          = S_IDLE;
                end else begin
                    o_cmd.probe_next = 1'b1;
                    n_state          = S_PROBE_RD;
                end
            end
            S_LINK: begin
                o_cmd.wr_sel     = WR_END_LINK;
                o_cmd.res_valid  = 1'b1;
                o_cmd.res_status = STAT_INSERTED;
                o_cmd.slot_sel   = SLOT_CAND;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/cht_dpath.sv]
// ----------------------------------------------------------------------------
// cht_dpath
// Datapath of the hash table: slot store, reciprocal remainder unit, chain
// and probe pointers, step counters and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cht_dpath #(
    parameter int TABLE_SLOTS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_kind,
    input  wire logic [cht_pkg::KEY_W-1:0]    i_key,
    input  wire cht_pkg::t_cmd                i_cmd,
    output cht_pkg::t_stat                    o_stat,
    output logic                              o_valid,
    output logic [cht_pkg::STATUS_W-1:0]      o_status,
    output logic [cht_pkg::SLOT_OUT_W-1:0]    o_slot_index
);
    import cht_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_SLOTS);
    localparam int EXT_W  = (IDX_W > SLOT_OUT_W) ? IDX_W : SLOT_OUT_W;
    localparam int PROD_W = KEY_W + 32;
    localparam logic [IDX_W:0]       N_VAL  = (IDX_W+1)'(TABLE_SLOTS);
    localparam logic [IDX_W-1:0]     N_LAST = IDX_W'(TABLE_SLOTS - 1);
    // floor(2^32 / table size), at most 2^31 for any table of two or more slots
    localparam logic [31:0]          RECIP  = 32'((64'd1 << 32) / TABLE_SLOTS);

    typedef struct packed {
        logic             used;
        logic             link_valid;
        logic [IDX_W-1:0] link;
        logic [KEY_W-1:0] key;
    } t_slot_word;

    // slot store
    t_slot_word r_mem [TABLE_SLOTS];
    t_slot_word r_rd_word;

    logic             r_kind;
    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] r_end_key;
    logic             r_mod_ph;
    logic [KEY_W-1:0] r_quot;
    logic [IDX_W-1:0] r_pos;
    logic [IDX_W-1:0] r_cand;
    logic [IDX_W-1:0] r_probe;
    logic [IDX_W:0]   r_steps;
    logic [IDX_W-1:0] r_clr;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    t_slot_word        wr_data;
    logic [IDX_W-1:0]  rd_addr;
    logic [PROD_W-1:0] mul_full;
    logic [IDX_W:0]    quot_n;
    logic [IDX_W:0]    rem_raw;
    logic [IDX_W:0]    rem_next;
    logic [IDX_W-1:0]  cand_next;
    logic [IDX_W-1:0]  slot_pick;
    logic [EXT_W-1:0]  slot_ext;

    // write port selection
    always_comb begin
        wr_en   = 1'b1;
        wr_addr = r_pos;
        wr_data = '{used: 1'b1, link_valid: 1'b0, link: '0, key: r_key};
        unique case (i_cmd.wr_sel)
            WR_NONE: begin
                wr_en = 1'b0;
            end
            WR_CLEAR: begin
                wr_addr = r_clr;
                wr_data = '0;
            end
            WR_POS_KEY: begin
                wr_addr = r_pos;
            end
            WR_CAND_KEY: begin
                wr_addr = r_cand;
            end
            WR_END_LINK: begin
                wr_addr = r_pos;
                wr_data = '{used: 1'b1, link_valid: 1'b1, link: r_cand, key: r_end_key};
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign rd_addr = (i_cmd.rd_sel == RD_CAND) ? r_cand : r_pos;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_word <= r_mem[rd_addr];
    end

    // home slot: quotient estimate from the reciprocal is exact or one low,
    // so the low bits of key - quotient*size need one compare and subtract
    assign mul_full = PROD_W'(r_key) * PROD_W'(RECIP);
    assign quot_n   = r_quot[IDX_W:0] * N_VAL;
    assign rem_raw  = r_key[IDX_W:0] - quot_n;
    assign rem_next = (rem_raw >= N_VAL) ? (rem_raw - N_VAL) : rem_raw;

    assign cand_next = (r_cand == N_LAST) ? '0 : (r_cand + 1'b1);

    // clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= (r_clr == N_LAST) ? '0 : (r_clr + 1'b1);
        end
    end

    // item registers, remainder, chain and probe pointers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= i_kind;
            r_key    <= i_key;
            r_mod_ph <= 1'b0;
            r_pos    <= '0;
            r_steps  <= '0;
        end else if (i_cmd.mod_step) begin
            r_mod_ph <= 1'b1;
            if (!r_mod_ph) begin
                r_quot <= mul_full[PROD_W-1:32];
            end else begin
                r_pos <= rem_next[IDX_W-1:0];
            end
        end else if (i_cmd.follow) begin
            r_pos   <= r_rd_word.link;
            r_steps <= r_steps + 1'b1;
        end
        if (i_cmd.probe_init) begin
            r_end_key <= r_rd_word.key;
            r_cand    <= (r_pos == N_LAST) ? '0 : (r_pos + 1'b1);
            r_probe   <= IDX_W'(1);
        end else if (i_cmd.probe_next) begin
            r_cand  <= cand_next;
            r_probe <= r_probe + 1'b1;
        end
    end

    // status towards the controller
    assign o_stat = '{
        kind:       r_kind,
        clr_last:   (r_clr == N_LAST),
        mod_done:   r_mod_ph,
        used:       r_rd_word.used,
        link_valid: r_rd_word.link_valid,
        key_match:  (r_rd_word.key == r_key),
        steps_lt_n: (r_steps < N_VAL),
        steps_last: (r_steps == {1'b0, N_LAST}),
        probe_last: (r_probe == N_LAST)
    };

    // result register
    always_comb begin
        unique case (i_cmd.slot_sel)
            SLOT_POS:  slot_pick = r_pos;
            SLOT_CAND: slot_pick = r_cand;
            default:   slot_pick = '0;
        endcase
    end

    assign slot_ext = EXT_W'(slot_pick);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.res_valid;
        end
        if (i_cmd.res_valid) begin
            o_status     <= i_cmd.res_status;
            o_slot_index <= slot_ext[SLOT_OUT_W-1:0];
        end
    end

endmodule

`default_nettype wire

[design/coalesced_hash_table.sv]
// ----------------------------------------------------------------------------
// coalesced_hash_table
// Coalesced-chaining hash table of TABLE_SLOTS slots with insert and find.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all TABLE_SLOTS slots with busy
// high. An item is taken when start is high and busy is low; busy stays high
// until its result has been issued. The result appears on o_status and
// o_slot_index for exactly one cycle with o_valid high and must be captured
// then, as it is not held. An item first needs the home slot remainder
// (a reciprocal multiply, then a correction), then a read and an evaluation
// of every slot visited on the chain and of every slot probed, through the
// single read port of the slot store, then the link write of a probed
// insert, and last the result register. Busy drops in the cycle the result
// is shown, so the next item can be taken then.
// ----------------------------------------------------------------------------
`default_nettype none

module coalesced_hash_table #(
    parameter int TABLE_SLOTS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_kind,
    input  wire logic [cht_pkg::KEY_W-1:0]     i_key,
    output logic                               o_valid,
    output logic [cht_pkg::STATUS_W-1:0]       o_status,
    output logic [cht_pkg::SLOT_OUT_W-1:0]     o_slot_index
);
    import cht_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // controller
    cht_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // datapath
    cht_dpath #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_kind       (i_kind),
        .i_key        (i_key),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_slot_index (o_slot_index)
    );

`ifndef SYNTHESIS
    // an accepted item keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // results come one per item, never in adjacent cycles
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for two cycles");

    // a result only follows a busy cycle
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result issued without an item in flight");

    // slot index is zero unless the key was stored or found
    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == STAT_DUPLICATE || o_status == STAT_FULL ||
                     o_status == STAT_NOT_FOUND)) |-> (o_slot_index == '0))
        else $error("slot index set on a miss result");
`endif

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the coalesced hash table. A scoreboard holds its own
// copy of the slot keys, used flags and chain links, and predicts status and
// slot for every item that the block accepts. A short directed run covers an
// empty table, key extremes, duplicates at home and down a chain, and probes
// that wrap. A random run of inserts and finds follows, with clustered home
// slots to grow long chains, under three sender idle settings.
// ----------------------------------------------------------------------------

module tb_top;

    import cht_pkg::*;

    localparam int SLOTS      = 16;
    localparam int SLOTS_OUT  = SLOT_OUT_W;
    localparam int CYCLE_CAP  = 1000000;
    localparam int PRINT_CAP  = 100;
    localparam int RAND_ITEMS = 580;
    localparam bit OP_INSERT  = 1'b0;
    localparam bit OP_FIND    = 1'b1;

    // slot store model and queue of predicted results
    class hash_scoreboard;
        bit [KEY_W-1:0]      slot_key  [SLOTS];
        bit                  slot_full [SLOTS];
        int                  slot_next [SLOTS];
        bit                  next_ok   [SLOTS];
        t_status             want_status[$];
        bit [SLOTS_OUT-1:0]  want_slot[$];
        int                  errors;

        function new();
            for (int s = 0; s < SLOTS; s++) begin
                slot_key[s]  = '0;
                slot_full[s] = 1'b0;
                slot_next[s] = 0;
                next_ok[s]   = 1'b0;
            end
            errors = 0;
        endfunction

        function void push_result(t_status st, int slot);
            want_status.push_back(st);
            want_slot.push_back(slot[SLOTS_OUT-1:0]);
        endfunction

        // insert: home slot, else chain walk, else linear probe from chain end
        function void predict_insert(bit [KEY_W-1:0] key);
            int pos;
            int steps;
            int cand;
            pos   = int'(key % SLOTS);
            steps = 0;
            if (!slot_full[pos]) begin
                slot_key[pos]  = key;
                slot_full[pos] = 1'b1;
                push_result(STAT_INSERTED, pos);
                return;
            end
            while (next_ok[pos] && slot_key[pos] != key && steps < SLOTS) begin
                pos = slot_next[pos];
                steps++;
            end
            if (slot_full[pos] && slot_key[pos] == key) begin
                push_result(STAT_DUPLICATE, 0);
                return;
            end
            for (int p = 1; p < SLOTS; p++) begin
                cand = (pos + p) % SLOTS;
                if (!slot_full[cand]) begin
                    slot_key[cand]  = key;
                    slot_full[cand] = 1'b1;
                    slot_next[pos]  = cand;
                    next_ok[pos]    = 1'b1;
                    push_result(STAT_INSERTED, cand);
                    return;
                end
            end
            push_result(STAT_FULL, 0);
        endfunction

        // find: walk the chain from home, comparing used slots only
        function void predict_find(bit [KEY_W-1:0] key);
            int pos;
            pos = int'(key % SLOTS);
            for (int steps = 0; steps < SLOTS; steps++) begin
                if (slot_full[pos] && slot_key[pos] == key) begin
                    push_result(STAT_FOUND, pos);
                    return;
                end
                if (!next_ok[pos])
                    break;
                pos = slot_next[pos];
            end
            push_result(STAT_NOT_FOUND, 0);
        endfunction

        function void note_item(bit kind, bit [KEY_W-1:0] key);
            if (kind == OP_INSERT)
                predict_insert(key);
            else
                predict_find(key);
        endfunction

        function int pending();
            return want_status.size();
        endfunction

        task report(string what);
            if (errors < PRINT_CAP)
                $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        task check_result(logic [STATUS_W-1:0] status, logic [SLOTS_OUT-1:0] slot);
            t_status             st;
            bit [SLOTS_OUT-1:0]  sl;
            if (want_status.size() == 0) begin
                report($sformatf("unexpected result status=%0d slot=%0d", status, slot));
                return;
            end
            st = want_status.pop_front();
            sl = want_slot.pop_front();
            if (status !== st)
                report($sformatf("status got %0d want %0d (%s)", status, st, st.name()));
            if (slot !== sl)
                report($sformatf("slot got %0d want %0d", slot, sl));
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  i_kind = 1'b0;
    logic [KEY_W-1:0]      i_key = '0;
    logic                  o_valid;
    logic [STATUS_W-1:0]   o_status;
    logic [SLOT_OUT_W-1:0] o_slot_index;

    hash_scoreboard        table_model = new();
    bit [KEY_W-1:0]        stored_keys[$];
    int                    idle_pct = 0;
    int                    cycle_count = 0;

    coalesced_hash_table #(
        .TABLE_SLOTS(SLOTS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_kind       (i_kind),
        .i_key        (i_key),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_slot_index (o_slot_index)
    );

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // result capture: the strobe lasts one cycle and cannot be held off
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1)
            table_model.check_result(o_status, o_slot_index);
    end

    // present one item, idling at random first, and note it once taken
    task automatic send_item(input bit kind, input bit [KEY_W-1:0] key);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_kind <= kind;
        i_key  <= key;
        do @(posedge i_clk); while (busy !== 1'b0);
        table_model.note_item(kind, key);
        if (kind == OP_INSERT && stored_keys.size() < 64)
            stored_keys.push_back(key);
    endtask

    // random item: new keys (often sharing few home slots) or keys seen before
    task automatic send_random();
        int             roll;
        bit             kind;
        bit [KEY_W-1:0] key;
        roll = $urandom_range(0, 99);
        kind = 1'($urandom_range(0, 1));
        key  = KEY_W'($urandom());
        if (roll < 35)
            key[3:0] = 4'(3 + $urandom_range(0, 2));
        else if (roll < 75 && stored_keys.size() > 0)
            key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        send_item(kind, key);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, extremes, duplicates, chain growth, wrap
        idle_pct = 30;
        send_item(OP_FIND,   31'd0);
        send_item(OP_FIND,   31'h7FFF_FFFF);
        send_item(OP_INSERT, 31'd0);
        send_item(OP_INSERT, 31'd0);
        send_item(OP_FIND,   31'd0);
        send_item(OP_INSERT, 31'd16);
        send_item(OP_INSERT, 31'h7FFF_FFFF);
        send_item(OP_INSERT, 31'd31);
        send_item(OP_INSERT, 31'd16);
        send_item(OP_INSERT, 31'd31);
        send_item(OP_FIND,   31'd31);
        send_item(OP_FIND,   31'd16);
        send_item(OP_FIND,   31'h7FFF_FFFF);
        send_item(OP_FIND,   31'd47);
        send_item(OP_FIND,   31'd32);
        send_item(OP_FIND,   31'h7FFF_FFF0);

        // random: three sender idle settings
        repeat (RAND_ITEMS) send_random();
        idle_pct = 67;
        repeat (RAND_ITEMS) send_random();
        idle_pct = 0;
        repeat (RAND_ITEMS) send_random();
        start <= 1'b0;

        // drain, then allow a few more cycles for any stray result
        while (table_model.pending() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (table_model.errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

[coalesced_hash_table.f]
design/cht_pkg.sv
design/cht_ctrl.sv
design/cht_dpath.sv
design/coalesced_hash_table.sv
tb/tb_top.sv
